// ----- design/tcw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: screen geometry,
// command and register codes, escape phases, controller states, character bytes.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS      = 80;
	localparam int ROWS         = 25;
	localparam int SCREEN_CELLS = COLUMNS * ROWS;

	// cell index width is fixed by the port fields
	localparam int CELL_W    = 11;
	localparam int CUR_EXT_W = CELL_W + 1;
	localparam int COL_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	localparam logic [CELL_W-1:0] LAST_ROW  = CELL_W'(SCREEN_CELLS - COLUMNS);
	localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(SCREEN_CELLS - 1);

	localparam logic [7:0] WHITE_ATTR = 8'b0000_1111;
	localparam logic [7:0] CH_ESC     = 8'h1B;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_BS      = 8'h08;
	localparam logic [7:0] CH_DEL     = 8'h7F;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_J       = 8'h4A;
	localparam logic [7:0] CH_H       = 8'h48;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_ESC  = 2'd1,
		PH_CSI  = 2'd2
	} phase_t;

	localparam logic [1:0] REG_TEXT_ATTR = 2'd0;
	localparam logic [1:0] REG_NL_RETURN = 2'd1;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_BLANK,
		ST_COPY,
		ST_FILL,
		ST_FINISH
	} state_t;

endpackage : tcw_pkg
`default_nettype wire

// ----- design/text_console_writer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text screen of character and attribute cells with cursor, escape decoding
// and scrolling, kept in two single-port-write character/attribute memories.
// ----------------------------------------------------------------------------
// Timing: after reset the block sweeps the screen store once, one cell a
// cycle, with in_ready low; configuration writes are taken meanwhile. A put,
// read or no-op transaction does its memory access when it is accepted; the
// result register is then loaded in the finish state once it is free. A clear
// walks the whole store. ESC [ J rewrites the character bytes from the cursor
// to the end, one cell a cycle. A put that runs past the last cell scrolls:
// the row copy streams through the memory read port and the last row is
// filled. The result register lets the next transaction be taken while a
// finished result still waits on out_ready.
module text_console_writer_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [1:0]                cfg_addr,
	input  wire logic [7:0]                cfg_wdata,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                cmd,
	input  wire logic [7:0]                char_code,
	input  wire logic [tcw_pkg::CELL_W-1:0] read_index,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [tcw_pkg::CELL_W-1:0]     cursor_cell,
	output logic [7:0]                     cell_char,
	output logic [7:0]                     cell_attr,
	output logic [1:0]                     escape_phase_out,
	output logic                           unknown_escape,
	output logic                           scrolled
);
	import tcw_pkg::*;

	// screen store
	logic [7:0] char_mem [SCREEN_CELLS];
	logic [7:0] attr_mem [SCREEN_CELLS];

	state_t state_q, state_d;

	logic [7:0]        text_attr_q;
	logic              nl_return_q;
	logic [CELL_W-1:0] cursor_q;
	logic [COL_W-1:0]  col_q;
	logic [1:0]        phase_q;
	logic [CELL_W-1:0] sweep_q;
	logic              unknown_q;
	logic              scrolled_q;
	logic              rd_ok_q;
	logic [7:0]        rd_char_q;
	logic [7:0]        rd_attr_q;

	logic              accept;
	logic              out_free;
	cmd_t              cmd_c;

	// memory control
	logic              ch_we;
	logic              at_we;
	logic [CELL_W-1:0] waddr;
	logic [7:0]        ch_wdata;
	logic [7:0]        at_wdata;
	logic              mem_re;
	logic [CELL_W-1:0] raddr;

	// put datapath
	logic [7:0]           pc;
	logic [CUR_EXT_W-1:0] cur_ext;
	logic [CUR_EXT_W-1:0] col_ext;
	logic [CUR_EXT_W-1:0] nx_cur;
	logic [COL_W-1:0]     nx_col;
	logic [1:0]           nx_ph;
	logic                 nx_unk;
	logic                 blank_go;
	logic                 put_wch;
	logic                 put_wat;
	logic [CELL_W-1:0]    put_waddr;
	logic [7:0]           put_ch;
	logic                 scroll_go;
	logic                 col_nz;
	logic                 rd_in_range;

	assign cmd_c       = cmd_t'(cmd);
	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign out_free    = !out_valid || out_ready;
	assign rd_in_range = (read_index < CELL_W'(SCREEN_CELLS));

	// ---------------------------------------------------------------- put logic
	always_comb begin
		pc        = (char_code == CH_TAB) ? CH_SPACE : char_code;
		cur_ext   = {1'b0, cursor_q};
		col_ext   = CUR_EXT_W'(col_q);
		col_nz    = (col_q != '0);
		nx_cur    = cur_ext;
		nx_col    = col_q;
		nx_ph     = phase_q;
		nx_unk    = 1'b0;
		blank_go  = 1'b0;
		put_wch   = 1'b0;
		put_wat   = 1'b0;
		put_waddr = cursor_q;
		put_ch    = pc;
		if (char_code == CH_LF && nl_return_q) begin
			// the CR goes through the escape decoder first, then LF acts alone
			if (phase_q == PH_IDLE) begin
				nx_cur = cur_ext - col_ext + CUR_EXT_W'(COLUMNS);
				nx_col = '0;
			end else begin
				nx_cur = cur_ext + CUR_EXT_W'(COLUMNS);
			end
			nx_unk = (phase_q == PH_CSI);
			nx_ph  = PH_IDLE;
		end else if (phase_q == PH_IDLE && char_code == CH_ESC) begin
			nx_ph = PH_ESC;
		end else if (phase_q == PH_ESC) begin
			nx_ph = (char_code == CH_LBRACK) ? PH_CSI : PH_IDLE;
		end else if (phase_q != PH_IDLE) begin
			if (char_code == CH_J) begin
				blank_go = 1'b1;
			end else if (char_code == CH_H) begin
				nx_cur = '0;
				nx_col = '0;
			end else begin
				nx_unk = 1'b1;
			end
			nx_ph = PH_IDLE;
		end else if (pc == CH_BS && col_nz) begin
			nx_cur = cur_ext - CUR_EXT_W'(1);
			nx_col = col_q - COL_W'(1);
		end else if (pc == CH_DEL && col_nz) begin
			nx_cur    = cur_ext - CUR_EXT_W'(1);
			nx_col    = col_q - COL_W'(1);
			put_wch   = 1'b1;
			put_waddr = cursor_q - CELL_W'(1);
			put_ch    = CH_SPACE;
		end else if (pc == CH_CR) begin
			nx_cur = cur_ext - col_ext;
			nx_col = '0;
		end else if (pc == CH_LF) begin
			nx_cur = cur_ext + CUR_EXT_W'(COLUMNS);
		end else begin
			put_wch = 1'b1;
			put_wat = 1'b1;
			nx_cur  = cur_ext + CUR_EXT_W'(1);
			nx_col  = (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + COL_W'(1);
		end
		scroll_go = (nx_cur >= CUR_EXT_W'(SCREEN_CELLS));
	end

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (sweep_q == LAST_CELL) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd_c)
						CMD_PUT: begin
							if (blank_go)       state_d = ST_BLANK;
							else if (scroll_go) state_d = ST_COPY;
							else                state_d = ST_FINISH;
						end
						CMD_CLEAR: state_d = ST_CLEAR;
						CMD_READ:  state_d = ST_FINISH;
						CMD_NOP:   state_d = ST_FINISH;
						default:   state_d = ST_FINISH;
					endcase
				end
			end
			ST_CLEAR, ST_BLANK: begin
				if (sweep_q == LAST_CELL) state_d = ST_FINISH;
			end
			ST_COPY: begin
				if (sweep_q == LAST_ROW) state_d = ST_FILL;
			end
			ST_FILL: begin
				if (sweep_q == LAST_CELL) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- memory control
	always_comb begin
		ch_we    = 1'b0;
		at_we    = 1'b0;
		waddr    = sweep_q;
		ch_wdata = 8'h00;
		at_wdata = WHITE_ATTR;
		mem_re   = 1'b0;
		raddr    = '0;
		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				ch_we = 1'b1;
				at_we = 1'b1;
			end
			ST_IDLE: begin
				if (accept && cmd_c == CMD_PUT) begin
					ch_we    = put_wch;
					at_we    = put_wat;
					waddr    = put_waddr;
					ch_wdata = put_ch;
					at_wdata = text_attr_q;
				end else if (accept && cmd_c == CMD_READ) begin
					mem_re = 1'b1;
					raddr  = rd_in_range ? read_index : '0;
				end
			end
			ST_BLANK: begin
				ch_we    = 1'b1;
				ch_wdata = CH_SPACE;
			end
			ST_COPY: begin
				// read one row ahead, write the cell read in the previous cycle
				mem_re   = (sweep_q != LAST_ROW);
				raddr    = sweep_q + CELL_W'(COLUMNS);
				ch_we    = (sweep_q != '0);
				at_we    = (sweep_q != '0);
				waddr    = sweep_q - CELL_W'(1);
				ch_wdata = rd_char_q;
				at_wdata = rd_attr_q;
			end
			ST_FILL: begin
				ch_we    = 1'b1;
				at_we    = 1'b1;
				ch_wdata = CH_SPACE;
			end
			ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------- memories
	always_ff @(posedge clk) begin
		if (ch_we) char_mem[waddr] <= ch_wdata;
		if (at_we) attr_mem[waddr] <= at_wdata;
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_char_q <= char_mem[raddr];
			rd_attr_q <= attr_mem[raddr];
		end
	end

	// ---------------------------------------------------------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			text_attr_q <= WHITE_ATTR;
			nl_return_q <= 1'b1;
			cursor_q    <= '0;
			col_q       <= '0;
			phase_q     <= PH_IDLE;
			sweep_q     <= '0;
			unknown_q   <= 1'b0;
			scrolled_q  <= 1'b0;
			rd_ok_q     <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_addr)
					REG_TEXT_ATTR: text_attr_q <= cfg_wdata;
					REG_NL_RETURN: nl_return_q <= cfg_wdata[0];
					default: ;
				endcase
			end

			if (accept) begin
				unknown_q  <= (cmd_c == CMD_PUT) && nx_unk;
				scrolled_q <= (cmd_c == CMD_PUT) && scroll_go && !blank_go;
				rd_ok_q    <= (cmd_c == CMD_READ) && rd_in_range;
				sweep_q    <= (cmd_c == CMD_PUT && blank_go) ? cursor_q : '0;
				if (cmd_c == CMD_PUT) begin
					phase_q <= nx_ph;
					if (scroll_go && !blank_go) begin
						cursor_q <= LAST_ROW;
						col_q    <= '0;
					end else if (!blank_go) begin
						cursor_q <= nx_cur[CELL_W-1:0];
						col_q    <= nx_col;
					end
				end else if (cmd_c == CMD_CLEAR) begin
					cursor_q <= '0;
					col_q    <= '0;
				end
			end else if (state_q == ST_COPY && sweep_q == LAST_ROW) begin
				sweep_q <= LAST_ROW;
			end else if (state_q == ST_INIT || state_q == ST_CLEAR || state_q == ST_BLANK ||
			             state_q == ST_COPY || state_q == ST_FILL) begin
				sweep_q <= (sweep_q == LAST_CELL) ? '0 : sweep_q + CELL_W'(1);
			end

			// result register: load on finish, drop when taken
			if (state_q == ST_FINISH && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			cursor_cell      <= cursor_q;
			cell_char        <= rd_ok_q ? rd_char_q : 8'h00;
			cell_attr        <= rd_ok_q ? rd_attr_q : 8'h00;
			escape_phase_out <= phase_q;
			unknown_escape   <= unknown_q;
			scrolled         <= scrolled_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q < CELL_W'(SCREEN_CELLS))
		else $error("cursor beyond last cell");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_W'(COLUMNS - 1) && (cursor_q >= CELL_W'(col_q)))
		else $error("column out of range");

	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("escape phase invalid");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !accept) |-> !ch_we && !at_we)
		else $error("memory write without transaction");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_free) |=> out_valid && state_q == ST_IDLE)
		else $error("result not loaded on finish");
`endif

endmodule : text_console_writer_top
`default_nettype wire
